@@ design/cv3_pkg.sv @@
// Shared types, constants and helpers of the 3x3 convolution block.
package cv3_pkg;

  // Defaults of the top level's parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_COEF_BITS  = 9;

  // Fixed field widths.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int RAW_W      = 21;
  localparam int SIZE_CFG_W = 11;
  localparam int KROW_W     = 27;
  localparam int CFG_DATA_W = 27;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KROW_ABOVE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KROW_MIDDLE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KROW_BELOW   = 3'd4;

  // Reset values of the registers.
  localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd810;
  localparam logic [SIZE_CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd540;
  localparam logic [KROW_W-1:0]     RST_KROW         = 27'd262657;

  // Result queue depth in items; pointers wrap on their own.
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;

  // One result as it leaves the block.
  typedef struct packed {
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [PIX_W-1:0]       value;
    logic signed [RAW_W-1:0] raw_sum;
  } res_t;

  // Everything one pixel causes: an interior result, a border result, or both.
  typedef struct packed {
    logic has_int;
    res_t int_res;
    logic has_bord;
    res_t bord_res;
  } entry_t;

  // Frame size as the hardware uses it: below 3 acts as 3, above the maximum as the maximum.
  function automatic int clamp_size(input logic [SIZE_CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (r < 3) begin
      r = 3;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

@@ design/cv3_line_store.sv @@
// Two line stores holding the two previous rows, one read and one write per cycle.
module cv3_line_store #(
  parameter int MAX_WIDTH = cv3_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  output logic [cv3_pkg::PIX_W-1:0]          rd_upper,
  output logic [cv3_pkg::PIX_W-1:0]          rd_lower,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  input  logic [cv3_pkg::PIX_W-1:0]          wr_upper,
  input  logic [cv3_pkg::PIX_W-1:0]          wr_lower
);
  import cv3_pkg::*;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_upper_r;
  logic [PIX_W-1:0] rd_lower_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r <= upper_mem[rd_addr];
      rd_lower_r <= lower_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

endmodule

@@ design/cv3_cell.sv @@
// One window column: three pixels, their three products and the registered column sum.
module cv3_cell #(
  parameter int COEF_BITS = cv3_pkg::DEF_COEF_BITS
) (
  input  logic                                  clk,
  input  logic                                  shift_en,
  input  logic [2:0][cv3_pkg::PIX_W-1:0]        col_in,
  input  logic [2:0][COEF_BITS-1:0]             coef,
  output logic [2:0][cv3_pkg::PIX_W-1:0]        col_out,
  output logic signed [COEF_BITS+10:0]          col_sum
);
  import cv3_pkg::*;

  localparam int PROD_W = COEF_BITS + 9;
  localparam int SUM_W  = COEF_BITS + 11;

  logic [2:0][PIX_W-1:0]     col_r;
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [PROD_W-1:0]  prod_nxt [3];
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;

  // Row 0 is the row above, row 2 the row below.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[r] = $signed(coef[r]) * $signed({1'b0, col_r[r]});
    end
    sum_nxt = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
  end

  // The column moves only on a pixel; products and sum follow it one stage each.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
    for (int r = 0; r < 3; r++) begin
      prod_r[r] <= prod_nxt[r];
    end
    sum_r <= sum_nxt;
  end

  assign col_out = col_r;
  assign col_sum = sum_r;

endmodule

@@ design/cv3_out_queue.sv @@
// Result queue with credit count and the output stage that sends one result per transfer.
module cv3_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              reserve,
  output logic              space_ok,
  input  logic              push,
  input  cv3_pkg::entry_t   push_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output cv3_pkg::res_t     out_res,
  output logic              out_border,
  output logic              out_last
);
  import cv3_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;
  logic                out_border_r, out_border_nxt;
  logic                out_last_r, out_last_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  res_t                pend_res_r, pend_res_nxt;
  logic                take;
  logic                pop;
  entry_t              head;

  // Credits count queued items plus items still in the pipeline that will push.
  assign space_ok = (used_r < CNT_W'(QUEUE_DEPTH));
  assign take     = !out_valid_r || out_ready;
  assign pop      = take && !pend_valid_r && (cnt_r != '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
    used_nxt   = used_r + CNT_W'(reserve) - CNT_W'(pop);
  end

  // The interior result goes first; a border result of the same pixel waits one transfer.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    out_border_nxt = out_border_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    if (take) begin
      out_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        out_border_nxt = 1'b1;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (cnt_r != '0) begin
        out_valid_nxt = 1'b1;
        if (head.has_int) begin
          out_res_nxt    = head.int_res;
          out_border_nxt = 1'b0;
          out_last_nxt   = !head.has_bord;
          pend_valid_nxt = head.has_bord;
          pend_res_nxt   = head.bord_res;
        end else begin
          out_res_nxt    = head.bord_res;
          out_border_nxt = 1'b1;
          out_last_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
    out_res_r    <= out_res_nxt;
    out_border_r <= out_border_nxt;
    out_last_r   <= out_last_nxt;
    pend_res_r   <= pend_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;
  assign out_border = out_border_r;
  assign out_last   = out_last_r;

endmodule

@@ design/conv3x3_border_passthrough_top.sv @@
// Top level of the streaming 3x3 convolution with border passthrough.
//
// Pixels enter in raster order on the in_ channel, one per transfer; in_tuser set
// marks the first pixel of a frame. Each border pixel leaves unchanged on the out_
// channel with out_tuser set; each interior pixel leaves as its 3x3 weighted sum once
// its lower-right neighbor has arrived, with out_tuser clear. out_tlast marks the last
// result caused by one input pixel; a pixel at the right edge from row 2 on or in the
// bottom row from column 2 on causes two results, the interior one first.
// Path of a result: the line store is read at the transfer, then come the window shift,
// products, column sums, queue write and the output register. Throughput: one pixel per
// cycle while in_tready is high, set by the line store that reads and writes in the same
// cycle and the three-cell window chain. The output register sends one result per cycle
// while out_tready is high, so a pixel with two results needs two output transfers; the
// 8-item queue absorbs the last pixel of a row, but along the bottom row it fills and
// in_tready then holds the input back between pixels.
// in_tready falls when queued plus in-flight items reach the queue depth; a stalled
// receiver fills the queue and then holds the input. Reset clears the counters and the
// queue and loads the register reset values; the line stores are not cleared and are
// written by the first rows of a frame. Configuration is written on cfg_wr_en.
module conv3x3_border_passthrough_top #(
  parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_BITS  = cv3_pkg::DEF_COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cv3_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cv3_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] pixel
  input  logic                              in_tuser,   // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cv3_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_x, out_y, value, raw_sum, zeros
  output logic                              out_tuser,  // is_border
  output logic                              out_tlast
);
  import cv3_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int KEXT_W = 3 * COEF_BITS;
  localparam int CSUM_W = COEF_BITS + 11;
  localparam int TOT_W  = COEF_BITS + 13;

  // Configuration, kept as last column and last row index.
  logic [XW-1:0]     wm1_r;
  logic [YW-1:0]     hm1_r;
  logic [KROW_W-1:0] krow_r [3];
  logic [KEXT_W-1:0] kext [3];

  // Raster counters.
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;

  // Accept stage.
  logic          accept;
  logic [XW-1:0] x_a;
  logic [YW-1:0] y_a;
  logic          int_a, bord_a;
  logic          hit_a;

  // Stage 1: line store data arrives.
  logic             s1_valid_r;
  logic [XW-1:0]    s1_x_r;
  logic [YW-1:0]    s1_y_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_int_r, s1_bord_r;
  logic             s1_hit_r;
  logic [PIX_W-1:0] s1_fwd_up_r, s1_fwd_lo_r;
  logic [PIX_W-1:0] ram_up, ram_lo;
  logic [PIX_W-1:0] a_eff, b_eff;

  // Stages 2 to 4 carry the pixel's own data beside the cell chain.
  logic             p_valid_r [3];
  logic [XW-1:0]    p_x_r [3];
  logic [YW-1:0]    p_y_r [3];
  logic [PIX_W-1:0] p_pix_r [3];
  logic             p_int_r [3];
  logic             p_bord_r [3];

  // Cell chain.
  logic [2:0][PIX_W-1:0]     col_new;
  logic [2:0][PIX_W-1:0]     col_link2, col_link1;
  logic [2:0][COEF_BITS-1:0] coef_c [3];
  logic signed [CSUM_W-1:0]  csum [3];
  logic signed [TOT_W-1:0]   total;

  entry_t push_entry;
  logic   push;
  logic   space_ok;
  res_t   out_res;
  logic   out_border;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r     <= XW'(clamp_size(RST_IMAGE_WIDTH, MAX_WIDTH) - 1);
      hm1_r     <= YW'(clamp_size(RST_IMAGE_HEIGHT, MAX_HEIGHT) - 1);
      krow_r[0] <= RST_KROW;
      krow_r[1] <= RST_KROW;
      krow_r[2] <= RST_KROW;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  wm1_r <= XW'(clamp_size(cfg_wdata[SIZE_CFG_W-1:0], MAX_WIDTH) - 1);
        REG_IMAGE_HEIGHT: hm1_r <= YW'(clamp_size(cfg_wdata[SIZE_CFG_W-1:0], MAX_HEIGHT) - 1);
        REG_KROW_ABOVE:   krow_r[0] <= cfg_wdata[KROW_W-1:0];
        REG_KROW_MIDDLE:  krow_r[1] <= cfg_wdata[KROW_W-1:0];
        REG_KROW_BELOW:   krow_r[2] <= cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient of row r and column offset c sits at bits c*COEF_BITS of that row's register.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      kext[r] = KEXT_W'(krow_r[r]);
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        coef_c[c][r] = kext[r][c*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // Position and result kinds of the arriving pixel.
  assign accept = in_tvalid && in_tready;
  assign x_a    = in_tuser ? '0 : col_r;
  assign y_a    = in_tuser ? '0 : row_r;
  assign int_a  = (x_a >= XW'(2)) && (y_a >= YW'(2)) && (x_a <= wm1_r) && (y_a <= hm1_r);
  assign bord_a = (x_a == '0) || (y_a == '0) || (x_a >= wm1_r) || (y_a >= hm1_r);

  // The line store read for this pixel sees the old contents if the pixel in stage 1
  // writes the same column in the same cycle; that pixel's write data is forwarded.
  assign hit_a  = s1_valid_r && (s1_x_r == x_a);

  always_comb begin
    if (x_a >= wm1_r) begin
      col_nxt = '0;
      row_nxt = (y_a >= hm1_r) ? '0 : y_a + YW'(1);
    end else begin
      col_nxt = x_a + XW'(1);
      row_nxt = y_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r      <= x_a;
      s1_y_r      <= y_a;
      s1_pix_r    <= in_tdata[PIX_W-1:0];
      s1_int_r    <= int_a;
      s1_bord_r   <= bord_a;
      s1_hit_r    <= hit_a;
      s1_fwd_up_r <= b_eff;
      s1_fwd_lo_r <= s1_pix_r;
    end
  end

  cv3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (x_a),
    .rd_upper (ram_up),
    .rd_lower (ram_lo),
    .wr_en    (s1_valid_r),
    .wr_addr  (s1_x_r),
    .wr_upper (b_eff),
    .wr_lower (s1_pix_r)
  );

  assign a_eff   = s1_hit_r ? s1_fwd_up_r : ram_up;
  assign b_eff   = s1_hit_r ? s1_fwd_lo_r : ram_lo;
  assign col_new = {s1_pix_r, b_eff, a_eff};

  // Right column takes the new pixels; each cell hands its column to the left neighbor.
  cv3_cell #(.COEF_BITS(COEF_BITS)) u_cell_right (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (col_new),
    .coef     (coef_c[2]),
    .col_out  (col_link2),
    .col_sum  (csum[2])
  );

  cv3_cell #(.COEF_BITS(COEF_BITS)) u_cell_mid (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (col_link2),
    .coef     (coef_c[1]),
    .col_out  (col_link1),
    .col_sum  (csum[1])
  );

  cv3_cell #(.COEF_BITS(COEF_BITS)) u_cell_left (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (col_link1),
    .coef     (coef_c[0]),
    .col_out  (),
    .col_sum  (csum[0])
  );

  // Pixel data follows the cell chain: stage 2 window column, stage 3 products, stage 4 column sums and total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) begin
        p_valid_r[s] <= 1'b0;
      end
    end else begin
      p_valid_r[0] <= s1_valid_r && (s1_int_r || s1_bord_r);
      p_valid_r[1] <= p_valid_r[0];
      p_valid_r[2] <= p_valid_r[1];
    end
  end

  always_ff @(posedge clk) begin
    p_x_r[0]    <= s1_x_r;
    p_y_r[0]    <= s1_y_r;
    p_pix_r[0]  <= s1_pix_r;
    p_int_r[0]  <= s1_int_r;
    p_bord_r[0] <= s1_bord_r;
    for (int s = 1; s < 3; s++) begin
      p_x_r[s]    <= p_x_r[s-1];
      p_y_r[s]    <= p_y_r[s-1];
      p_pix_r[s]  <= p_pix_r[s-1];
      p_int_r[s]  <= p_int_r[s-1];
      p_bord_r[s] <= p_bord_r[s-1];
    end
  end

  assign total = TOT_W'(csum[0]) + TOT_W'(csum[1]) + TOT_W'(csum[2]);
  assign push  = p_valid_r[2];

  always_comb begin
    push_entry.has_int          = p_int_r[2];
    push_entry.int_res.x        = COORD_W'(p_x_r[2] - XW'(1));
    push_entry.int_res.y        = COORD_W'(p_y_r[2] - YW'(1));
    push_entry.int_res.value    = total[PIX_W-1:0];
    push_entry.int_res.raw_sum  = RAW_W'(total);
    push_entry.has_bord         = p_bord_r[2];
    push_entry.bord_res.x       = COORD_W'(p_x_r[2]);
    push_entry.bord_res.y       = COORD_W'(p_y_r[2]);
    push_entry.bord_res.value   = p_pix_r[2];
    push_entry.bord_res.raw_sum = RAW_W'(p_pix_r[2]);
  end

  cv3_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .reserve    (accept && (int_a || bord_a)),
    .space_ok   (space_ok),
    .push       (push),
    .push_entry (push_entry),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res),
    .out_border (out_border),
    .out_last   (out_tlast)
  );

  assign in_tready = space_ok;
  assign out_tuser = out_border;
  assign out_tdata = {7'd0, out_res.raw_sum, out_res.value, out_res.y, out_res.x};

endmodule
